// ----- hw/rtl/irs_pkg.sv -----
// Shared types and constants for the integer range set core.
// Holds the range table entry layout, request/status codes and sequencer states.
// No dependencies.
`default_nettype none

package irs_pkg;

  localparam int MAX_RANGES = 16;
  localparam int KEY_BITS   = 32;
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_POST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] first;
    logic [KEY_BITS-1:0] last;
  } entry_t;

  typedef struct packed {
    logic key_lt_a;
    logic key_le_b;
    logic b_eq_km1;
    logic a_eq_kp1;
    logic a_eq_b;
    logic key_eq_a;
    logic key_eq_b;
  } flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/integer_range_set_core.sv -----
// Top level of the integer range set core: request sequencer and datapath.
// Depends on irs_pkg, irs_table and irs_alu.
//
// Keys live as sorted, disjoint, non-adjacent ranges in a table of MAX_RANGES
// entries with one read port and one write port. A request is taken when start
// is high and busy is low; its result appears on status, key_out and ranges_used
// for exactly one cycle with done high and must be captured then. A request
// first scans the table to locate its place (one entry read per cycle, stopping
// early when the place is found), then decides; where ranges must move up or
// down it shifts them one entry at a time and then writes any pending entry,
// then raises done. Pop on an empty set and the unused mode go straight from
// idle to done. The single table read port is what paces the scan and shift.
// A new request may be started in the cycle done is high.
`default_nettype none

module integer_range_set_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    mode,
  input  wire logic [irs_pkg::KEY_BITS-1:0]  key_in,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [irs_pkg::KEY_BITS-1:0]       key_out,
  output logic [irs_pkg::CNT_W-1:0]          ranges_used
);
  import irs_pkg::*;

  state_t              state, state_next;
  logic [1:0]          mode_r, mode_r_next;
  logic [KEY_BITS-1:0] key, key_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CNT_W-1:0]    rd_idx, rd_idx_next;
  logic [CNT_W-1:0]    q_idx, q_idx_next;
  logic                q_valid, q_valid_next;
  logic [CNT_W-1:0]    pos, pos_next;
  logic                has_prev, has_prev_next;
  logic                has_cur, has_cur_next;
  entry_t              prev, prev_next;
  entry_t              cur, cur_next;
  logic                shift_up, shift_up_next;
  logic [CNT_W-1:0]    remain, remain_next;
  logic                post_we, post_we_next;
  logic [CNT_W-1:0]    post_addr, post_addr_next;
  entry_t              post_data, post_data_next;
  stat_t               stat_r, stat_next;
  logic [KEY_BITS-1:0] key_out_r, key_out_next;

  logic                we;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;
  logic [IDX_W-1:0]    rd_addr;
  entry_t              rd_data;

  logic [KEY_BITS-1:0] a_op, b_op, key_m1, key_p1, a_p1;
  flags_t              flags;

  logic [CNT_W-1:0]    pos_m1, cnt_m1, q_dst;
  logic                accept, found, adj_l, adj_r, full;

  irs_table u_table (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  irs_alu u_alu (
    .key    (key),
    .a      (a_op),
    .b      (b_op),
    .flags  (flags),
    .key_m1 (key_m1),
    .key_p1 (key_p1),
    .a_p1   (a_p1)
  );

  always_comb begin
    if (state == S_SCAN) begin
      a_op = rd_data.first;
      b_op = rd_data.last;
    end else if (mode_r == MODE_REMOVE) begin
      a_op = prev.first;
      b_op = prev.last;
    end else if (mode_r == MODE_INSERT) begin
      a_op = cur.first;
      b_op = prev.last;
    end else begin
      a_op = cur.first;
      b_op = cur.last;
    end
  end

  assign busy        = (state != S_IDLE) && (state != S_DONE);
  assign done        = state == S_DONE;
  assign status      = stat_r;
  assign key_out     = key_out_r;
  assign ranges_used = cnt;

  assign accept = start && !busy;
  assign pos_m1 = pos - 1'b1;
  assign cnt_m1 = cnt - 1'b1;
  assign q_dst  = shift_up ? (q_idx + 1'b1) : (q_idx - 1'b1);
  assign found  = (mode_r == MODE_POP) || flags.key_lt_a;
  assign adj_l  = has_prev && flags.b_eq_km1;
  assign adj_r  = has_cur && flags.a_eq_kp1;
  assign full   = cnt >= CNT_W'(MAX_RANGES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      q_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      q_valid <= q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_r_next;
    key       <= key_next;
    rd_idx    <= rd_idx_next;
    q_idx     <= q_idx_next;
    pos       <= pos_next;
    has_prev  <= has_prev_next;
    has_cur   <= has_cur_next;
    prev      <= prev_next;
    cur       <= cur_next;
    shift_up  <= shift_up_next;
    remain    <= remain_next;
    post_we   <= post_we_next;
    post_addr <= post_addr_next;
    post_data <= post_data_next;
    stat_r    <= stat_next;
    key_out_r <= key_out_next;
  end

  always_comb begin
    state_next     = state;
    mode_r_next    = mode_r;
    key_next       = key;
    cnt_next       = cnt;
    rd_idx_next    = rd_idx;
    q_idx_next     = q_idx;
    q_valid_next   = 1'b0;
    pos_next       = pos;
    has_prev_next  = has_prev;
    has_cur_next   = has_cur;
    prev_next      = prev;
    cur_next       = cur;
    shift_up_next  = shift_up;
    remain_next    = remain;
    post_we_next   = post_we;
    post_addr_next = post_addr;
    post_data_next = post_data;
    stat_next      = stat_r;
    key_out_next   = key_out_r;
    we             = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_addr        = rd_idx[IDX_W-1:0];

    unique case (state)
      S_IDLE, S_DONE: begin
        if (accept) begin
          mode_r_next   = mode;
          key_next      = key_in;
          key_out_next  = '0;
          stat_next     = STAT_DONE;
          has_prev_next = 1'b0;
          has_cur_next  = 1'b0;
          pos_next      = cnt;
          rd_idx_next   = '0;
          post_we_next  = 1'b0;
          if (mode == MODE_POP && cnt == '0) begin
            stat_next  = STAT_EMPTY;
            state_next = S_DONE;
          end else if (mode == MODE_INSERT || mode == MODE_REMOVE || mode == MODE_POP) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end

      S_SCAN: begin
        if (q_valid && found) begin
          pos_next     = q_idx;
          cur_next     = rd_data;
          has_cur_next = 1'b1;
          state_next   = S_DECIDE;
        end else begin
          if (q_valid) begin
            prev_next     = rd_data;
            has_prev_next = 1'b1;
          end
          if (rd_idx < cnt) begin
            q_valid_next = 1'b1;
            q_idx_next   = rd_idx;
            rd_idx_next  = rd_idx + 1'b1;
          end else if (!q_valid) begin
            pos_next   = cnt;
            state_next = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        state_next = S_DONE;
        unique case (mode_r)
          MODE_INSERT: begin
            if (has_prev && flags.key_le_b) begin
              stat_next = STAT_DONE;
            end else if (adj_l && adj_r) begin
              we            = 1'b1;
              wr_addr       = pos_m1[IDX_W-1:0];
              wr_data       = '{first: prev.first, last: cur.last};
              rd_idx_next   = pos + 1'b1;
              remain_next   = cnt_m1 - pos;
              shift_up_next = 1'b0;
              cnt_next      = cnt_m1;
              state_next    = S_SHIFT;
            end else if (adj_l) begin
              we      = 1'b1;
              wr_addr = pos_m1[IDX_W-1:0];
              wr_data = '{first: prev.first, last: key};
            end else if (adj_r) begin
              we      = 1'b1;
              wr_addr = pos[IDX_W-1:0];
              wr_data = '{first: key, last: cur.last};
            end else if (full) begin
              stat_next = STAT_FULL;
            end else begin
              rd_idx_next    = cnt_m1;
              remain_next    = cnt - pos;
              shift_up_next  = 1'b1;
              post_we_next   = 1'b1;
              post_addr_next = pos;
              post_data_next = '{first: key, last: key};
              cnt_next       = cnt + 1'b1;
              state_next     = S_SHIFT;
            end
          end
          MODE_REMOVE: begin
            if (!has_prev || !flags.key_le_b) begin
              stat_next = STAT_ABSENT;
            end else if (flags.a_eq_b) begin
              rd_idx_next   = pos;
              remain_next   = cnt - pos;
              shift_up_next = 1'b0;
              cnt_next      = cnt_m1;
              state_next    = S_SHIFT;
            end else if (flags.key_eq_a) begin
              we      = 1'b1;
              wr_addr = pos_m1[IDX_W-1:0];
              wr_data = '{first: key_p1, last: prev.last};
            end else if (flags.key_eq_b) begin
              we      = 1'b1;
              wr_addr = pos_m1[IDX_W-1:0];
              wr_data = '{first: prev.first, last: key_m1};
            end else if (full) begin
              stat_next = STAT_FULL;
            end else begin
              we             = 1'b1;
              wr_addr        = pos_m1[IDX_W-1:0];
              wr_data        = '{first: prev.first, last: key_m1};
              rd_idx_next    = cnt_m1;
              remain_next    = cnt - pos;
              shift_up_next  = 1'b1;
              post_we_next   = 1'b1;
              post_addr_next = pos;
              post_data_next = '{first: key_p1, last: prev.last};
              cnt_next       = cnt + 1'b1;
              state_next     = S_SHIFT;
            end
          end
          default: begin
            key_out_next = cur.first;
            if (flags.a_eq_b) begin
              rd_idx_next   = CNT_W'(1);
              remain_next   = cnt_m1;
              shift_up_next = 1'b0;
              cnt_next      = cnt_m1;
              state_next    = S_SHIFT;
            end else begin
              we      = 1'b1;
              wr_addr = '0;
              wr_data = '{first: a_p1, last: cur.last};
            end
          end
        endcase
      end

      S_SHIFT: begin
        if (q_valid) begin
          we      = 1'b1;
          wr_addr = q_dst[IDX_W-1:0];
          wr_data = rd_data;
        end
        if (remain != '0) begin
          q_valid_next = 1'b1;
          q_idx_next   = rd_idx;
          rd_idx_next  = shift_up ? (rd_idx - 1'b1) : (rd_idx + 1'b1);
          remain_next  = remain - 1'b1;
        end else if (!q_valid) begin
          state_next = S_POST;
        end
      end

      S_POST: begin
        if (post_we) begin
          we      = 1'b1;
          wr_addr = post_addr[IDX_W-1:0];
          wr_data = post_data;
        end
        state_next = S_DONE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/irs_table.sv -----
// Range table storage: one write port, one read port with registered read data.
// Depends on irs_pkg for the entry layout and depth.
`default_nettype none

module irs_table (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [irs_pkg::IDX_W-1:0] wr_addr,
  input  wire irs_pkg::entry_t      wr_data,
  input  wire logic [irs_pkg::IDX_W-1:0] rd_addr,
  output irs_pkg::entry_t           rd_data
);
  import irs_pkg::*;

  entry_t mem [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/irs_alu.sv -----
// Shared compare and increment unit: compares the request key against one
// pair of range bounds and forms the key and bound neighbors. Depends on irs_pkg.
`default_nettype none

module irs_alu (
  input  wire logic [irs_pkg::KEY_BITS-1:0] key,
  input  wire logic [irs_pkg::KEY_BITS-1:0] a,
  input  wire logic [irs_pkg::KEY_BITS-1:0] b,
  output irs_pkg::flags_t                   flags,
  output logic [irs_pkg::KEY_BITS-1:0]      key_m1,
  output logic [irs_pkg::KEY_BITS-1:0]      key_p1,
  output logic [irs_pkg::KEY_BITS-1:0]      a_p1
);
  import irs_pkg::*;

  always_comb begin
    key_m1         = key - 1'b1;
    key_p1         = key + 1'b1;
    a_p1           = a + 1'b1;
    flags.key_lt_a = key < a;
    flags.key_le_b = key <= b;
    flags.b_eq_km1 = (key != '0) && (b == key_m1);
    flags.a_eq_kp1 = (key != '1) && (a == key_p1);
    flags.a_eq_b   = a == b;
    flags.key_eq_a = key == a;
    flags.key_eq_b = key == b;
  end

endmodule

`default_nettype wire
